[rtl/mpp_pkg.sv]
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types and constants for the mail path parser.
// ----------------------------------------------------------------------------
package mpp_pkg;

  localparam int unsigned MaxLenDef = 256;

  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatMultiAt  = 2'd1;
  localparam logic [1:0] StatStrayPar = 2'd2;
  localparam logic [1:0] StatOpenCmt  = 2'd3;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_AT,
    CLS_COLON,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_LT,
    CLS_GT
  } char_cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_final;
    logic       is_zero;
    logic       is_space;
    logic       is_print;
    char_cls_e  cls;
  } beat_t;

endpackage

[rtl/mail_path_parser.sv]
// ----------------------------------------------------------------------------
// mail_path_parser
// Normalizes a mailbox path given one byte per beat; reports on the end beat.
// ----------------------------------------------------------------------------
// One byte per beat in, one result beat out for every input beat. The block
// sustains one beat per clock while the sink keeps up: a front stage
// classifies each byte into a 2-entry queue, and the parse state machine
// retires one queued byte per cycle into an output register. Either side
// may stall; the queue absorbs the difference. Kept characters stream out
// as they arrive; the end beat also carries status, path length and the
// '@' position. No clearing pass after reset.
module mail_path_parser
  import mpp_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       char_valid_o,
  output logic [7:0] out_char_o,
  output logic       path_done_o,
  output logic [1:0] status_o,
  output logic [7:0] path_length_o,
  output logic [7:0] delimiter_at_o
);

  logic  head_valid;
  beat_t head;
  logic  pop;

  mpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .is_final_i   (is_final_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  mpp_back #(
    .MaxLen (MaxLen)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_valid_o   (char_valid_o),
    .out_char_o     (out_char_o),
    .path_done_o    (path_done_o),
    .status_o       (status_o),
    .path_length_o  (path_length_o),
    .delimiter_at_o (delimiter_at_o)
  );

endmodule

[rtl/mpp_front.sv]
// ----------------------------------------------------------------------------
// mpp_front
// Accepts input beats, classifies the byte and holds them in a 2-entry queue.
// ----------------------------------------------------------------------------
module mpp_front
  import mpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       head_valid_o,
  output beat_t      head_o,
  input  logic       pop_i
);

  beat_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  beat_t      cls_beat;
  logic       push;
  logic       pop;

  always_comb begin
    cls_beat          = '0;
    cls_beat.ch       = in_byte_i;
    cls_beat.is_final = is_final_i;
    cls_beat.is_zero  = (in_byte_i == 8'h00);
    cls_beat.is_space = (in_byte_i == 8'h20) ||
                        ((in_byte_i >= 8'h09) && (in_byte_i <= 8'h0D));
    cls_beat.is_print = (in_byte_i >= 8'h20) && (in_byte_i <= 8'h7E);
    case (in_byte_i)
      ChAt:     cls_beat.cls = CLS_AT;
      ChColon:  cls_beat.cls = CLS_COLON;
      ChQuote:  cls_beat.cls = CLS_QUOTE;
      ChBslash: cls_beat.cls = CLS_BSLASH;
      ChLparen: cls_beat.cls = CLS_LPAREN;
      ChRparen: cls_beat.cls = CLS_RPAREN;
      ChLt:     cls_beat.cls = CLS_LT;
      ChGt:     cls_beat.cls = CLS_GT;
      default:  cls_beat.cls = CLS_OTHER;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_beat;
    end
  end

endmodule

[rtl/mpp_back.sv]
// ----------------------------------------------------------------------------
// mpp_back
// Parse FSM: one queued beat per unstalled cycle into an output register.
// ----------------------------------------------------------------------------
module mpp_back
  import mpp_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  beat_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       char_valid_o,
  output logic [7:0] out_char_o,
  output logic       path_done_o,
  output logic [1:0] status_o,
  output logic [7:0] path_length_o,
  output logic [7:0] delimiter_at_o
);

  localparam logic [7:0] CapCnt = 8'(MaxLen - 1);

  typedef enum logic [2:0] {
    MODE_LEAD,
    MODE_NORMAL,
    MODE_ROUTE,
    MODE_ESCAPE,
    MODE_COMMENT,
    MODE_DONE
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       quotes_q, quotes_d;
  logic [7:0] kept_q, kept_d;
  logic [7:0] delim_q, delim_d;
  logic       first_at_q, first_at_d;
  logic [1:0] err_q, err_d;

  logic       ovalid_q;
  logic       cvalid_q, cvalid_d;
  logic [7:0] ochar_q, ochar_d;
  logic       done_q, done_d;
  logic [1:0] stat_q, stat_d;
  logic [7:0] len_q, len_d;
  logic [7:0] dat_q, dat_d;

  logic       step;
  logic       keep_req;
  logic       run_normal;

  assign step  = head_valid_i && (!ovalid_q || out_ready_i);
  assign pop_o = step;

  always_comb begin
    mode_d     = mode_q;
    quotes_d   = quotes_q;
    kept_d     = kept_q;
    delim_d    = delim_q;
    first_at_d = first_at_q;
    err_d      = err_q;
    keep_req   = 1'b0;
    run_normal = 1'b0;
    cvalid_d   = 1'b0;
    ochar_d    = 8'h00;
    done_d     = 1'b0;
    stat_d     = StatOk;
    len_d      = 8'h00;
    dat_d      = 8'h00;

    if (mode_q != MODE_DONE) begin
      if (head_i.is_zero) begin
        if (mode_q == MODE_COMMENT && err_q == StatOk) begin
          err_d = StatOpenCmt;
        end
        mode_d = MODE_DONE;
      end else begin
        case (mode_q)
          MODE_LEAD: begin
            if (!head_i.is_space) begin
              mode_d     = MODE_NORMAL;
              run_normal = 1'b1;
            end
          end
          MODE_ROUTE: begin
            if (head_i.cls == CLS_COLON) begin
              mode_d = MODE_NORMAL;
            end
          end
          MODE_ESCAPE: begin
            mode_d   = MODE_NORMAL;
            keep_req = 1'b1;
          end
          MODE_COMMENT: begin
            if (head_i.cls == CLS_RPAREN) begin
              mode_d = MODE_NORMAL;
            end
          end
          MODE_NORMAL: run_normal = 1'b1;
          default:     mode_d = MODE_DONE;
        endcase
      end
    end

    if (run_normal) begin
      case (head_i.cls)
        CLS_AT: begin
          if (kept_q == 8'h00) begin
            mode_d = MODE_ROUTE;
          end else if (quotes_q) begin
            keep_req = 1'b1;
          end else if (delim_q == 8'h00 && !first_at_q) begin
            delim_d  = kept_q;
            keep_req = 1'b1;
          end else begin
            err_d  = StatMultiAt;
            mode_d = MODE_DONE;
          end
        end
        CLS_QUOTE:  quotes_d = ~quotes_q;
        CLS_BSLASH: mode_d = MODE_ESCAPE;
        CLS_LPAREN: mode_d = MODE_COMMENT;
        CLS_RPAREN: begin
          err_d  = StatStrayPar;
          mode_d = MODE_DONE;
        end
        CLS_LT: keep_req = quotes_q;
        CLS_GT: begin
          if (quotes_q) begin
            keep_req = 1'b1;
          end else begin
            mode_d = MODE_DONE;
          end
        end
        default: keep_req = 1'b1;
      endcase
    end

    if (keep_req && head_i.is_print) begin
      if (kept_q == 8'h00 && head_i.ch == ChAt) begin
        first_at_d = 1'b1;
      end
      cvalid_d = 1'b1;
      ochar_d  = head_i.ch;
      kept_d   = kept_q + 8'd1;
      if (kept_d >= CapCnt) begin
        mode_d = MODE_DONE;
      end
    end

    if (head_i.is_final) begin
      if (mode_d == MODE_COMMENT && err_d == StatOk) begin
        err_d = StatOpenCmt;
      end
      done_d     = 1'b1;
      stat_d     = err_d;
      len_d      = kept_d;
      dat_d      = (delim_d != 8'h00) ? delim_d : kept_d;
      mode_d     = MODE_LEAD;
      quotes_d   = 1'b0;
      kept_d     = 8'h00;
      delim_d    = 8'h00;
      first_at_d = 1'b0;
      err_d      = StatOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_LEAD;
      quotes_q   <= 1'b0;
      kept_q     <= 8'h00;
      delim_q    <= 8'h00;
      first_at_q <= 1'b0;
      err_q      <= StatOk;
      ovalid_q   <= 1'b0;
    end else begin
      if (step) begin
        mode_q     <= mode_d;
        quotes_q   <= quotes_d;
        kept_q     <= kept_d;
        delim_q    <= delim_d;
        first_at_q <= first_at_d;
        err_q      <= err_d;
        ovalid_q   <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      cvalid_q <= cvalid_d;
      ochar_q  <= ochar_d;
      done_q   <= done_d;
      stat_q   <= stat_d;
      len_q    <= len_d;
      dat_q    <= dat_d;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign char_valid_o   = cvalid_q;
  assign out_char_o     = ochar_q;
  assign path_done_o    = done_q;
  assign status_o       = stat_q;
  assign path_length_o  = len_q;
  assign delimiter_at_o = dat_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mail_path_parser. Paths go in one byte per beat with
// random burst gaps on the input side and a stalling sink on the output side.
// A byte-level parser model predicts every output beat; outputs are compared
// field by field in order. Directed paths cover delimiters, source routes,
// quoting, escapes, comments, errors, odd bytes and the length cap, followed
// by random, mostly well-formed paths mixed with raw noise.
// ----------------------------------------------------------------------------
module tb_top
  import mpp_pkg::*;
;

  localparam int MaxLen     = MaxLenDef;
  localparam int CycleLimit = 300000;
  localparam int RandBeats  = 230;

  typedef enum logic [2:0] {
    PM_LEAD, PM_NORMAL, PM_ROUTE, PM_ESCAPE, PM_COMMENT, PM_DONE
  } pmode_e;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  typedef struct packed {
    logic       char_v;
    logic [7:0] ch;
    logic       done;
    logic [1:0] stat;
    logic [7:0] len;
    logic [7:0] at;
  } path_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       is_final = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       char_valid;
  logic [7:0] out_char;
  logic       path_done;
  logic [1:0] status;
  logic [7:0] path_length;
  logic [7:0] delimiter_at;

  path_beat_t parsed_q[$];
  logic [7:0] path_bytes[$];
  int         fails = 0;
  int         cycles = 0;
  int         beats_sent = 0;
  int         burst_left = 0;
  bit         tx_gaps = 1'b0;
  rx_mode_e   rx_mode = RX_OPEN;

  // parser model state
  pmode_e     pmode;
  logic       quoted;
  logic [7:0] kept_n;
  logic [7:0] at_pos;
  logic       lead_at;
  logic [1:0] err_code;
  logic       emit_v;
  logic [7:0] emit_ch;

  mail_path_parser #(.MaxLen(MaxLen)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .is_final_i     (is_final),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .char_valid_o   (char_valid),
    .out_char_o     (out_char),
    .path_done_o    (path_done),
    .status_o       (status),
    .path_length_o  (path_length),
    .delimiter_at_o (delimiter_at)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
      default:   out_ready <= ((cycles % 7) < 4);
    endcase
  end

  // ---------------------------------------------------------------- model
  function automatic void clear_parse();
    pmode    = PM_LEAD;
    quoted   = 1'b0;
    kept_n   = 8'd0;
    at_pos   = 8'd0;
    lead_at  = 1'b0;
    err_code = StatOk;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void keep_byte(logic [7:0] c);
    if (c < 8'h20 || c > 8'h7E) return;
    if (kept_n == 8'd0 && c == ChAt) lead_at = 1'b1;
    emit_v  = 1'b1;
    emit_ch = c;
    kept_n  = kept_n + 8'd1;
    if (kept_n >= 8'(MaxLen - 1)) pmode = PM_DONE;
  endfunction

  function automatic void parse_normal(logic [7:0] c);
    case (c)
      ChAt: begin
        if (kept_n == 8'd0) begin
          pmode = PM_ROUTE;
        end else if (quoted) begin
          keep_byte(c);
        end else if (at_pos == 8'd0 && !lead_at) begin
          at_pos = kept_n;
          keep_byte(c);
        end else begin
          err_code = StatMultiAt;
          pmode    = PM_DONE;
        end
      end
      ChQuote:  quoted = !quoted;
      ChBslash: pmode = PM_ESCAPE;
      ChLparen: pmode = PM_COMMENT;
      ChRparen: begin
        err_code = StatStrayPar;
        pmode    = PM_DONE;
      end
      ChLt: if (quoted) keep_byte(c);
      ChGt: begin
        if (quoted) keep_byte(c);
        else pmode = PM_DONE;
      end
      default: keep_byte(c);
    endcase
  endfunction

  function automatic path_beat_t parse_path_byte(logic [7:0] c, logic fin);
    path_beat_t r;
    r       = '0;
    emit_v  = 1'b0;
    emit_ch = 8'h00;
    if (pmode != PM_DONE) begin
      if (c == 8'h00) begin
        if (pmode == PM_COMMENT && err_code == StatOk) err_code = StatOpenCmt;
        pmode = PM_DONE;
      end else begin
        case (pmode)
          PM_LEAD: begin
            if (!is_ws(c)) begin
              pmode = PM_NORMAL;
              parse_normal(c);
            end
          end
          PM_ROUTE:   if (c == ChColon) pmode = PM_NORMAL;
          PM_ESCAPE: begin
            pmode = PM_NORMAL;
            keep_byte(c);
          end
          PM_COMMENT: if (c == ChRparen) pmode = PM_NORMAL;
          PM_NORMAL:  parse_normal(c);
          default:    pmode = PM_DONE;
        endcase
      end
    end
    r.char_v = emit_v;
    r.ch     = emit_ch;
    if (fin) begin
      if (pmode == PM_COMMENT && err_code == StatOk) err_code = StatOpenCmt;
      r.done = 1'b1;
      r.stat = err_code;
      r.len  = kept_n;
      r.at   = (at_pos != 8'd0) ? at_pos : kept_n;
      clear_parse();
    end
    return r;
  endfunction

  // -------------------------------------------------------------- checking
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    path_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (parsed_q.size() == 0) begin
        $error("output beat with no expected beat pending");
        fails++;
      end else begin
        want = parsed_q.pop_front();
        check_field("char_valid", 8'(want.char_v), 8'(char_valid));
        check_field("out_char", want.ch, out_char);
        check_field("path_done", 8'(want.done), 8'(path_done));
        check_field("status", 8'(want.stat), 8'(status));
        check_field("path_length", want.len, path_length);
        check_field("delimiter_at", want.at, delimiter_at);
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    is_final <= fin;
    do @(posedge clk); while (!in_ready);
    parsed_q.push_back(parse_path_byte(b, fin));
    beats_sent++;
  endtask

  task automatic send_path(input string s, input logic close = 1'b1);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], close && i == s.len() - 1);
  endtask

  task automatic send_queued();
    foreach (path_bytes[i]) send_beat(path_bytes[i], i == path_bytes.size() - 1);
  endtask

  function automatic void add_word(int n);
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) path_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      else path_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end
  endfunction

  function automatic void build_random_path();
    int n;
    path_bytes.delete();
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) path_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1)) path_bytes.push_back(8'h20);
      else path_bytes.push_back(8'($urandom_range(9, 13)));
    end
    if ($urandom_range(0, 4) == 0) begin
      path_bytes.push_back(ChAt);
      add_word($urandom_range(1, 4));
      path_bytes.push_back(ChColon);
    end
    if ($urandom_range(0, 1)) path_bytes.push_back(ChLt);
    if ($urandom_range(0, 29) == 0) begin
      add_word($urandom_range(240, 300));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 11))
          0: path_bytes.push_back(ChQuote);
          1: begin
            path_bytes.push_back(ChBslash);
            path_bytes.push_back(8'($urandom_range(0, 255)));
          end
          2: begin
            path_bytes.push_back(ChLparen);
            add_word($urandom_range(0, 3));
            path_bytes.push_back(ChRparen);
          end
          3: path_bytes.push_back($urandom_range(0, 1) ? ChLt : ChGt);
          default: add_word(1);
        endcase
      end
    end
    if ($urandom_range(0, 19) < 17) begin
      path_bytes.push_back(ChAt);
      add_word($urandom_range(1, 6));
    end
    case ($urandom_range(0, 11))
      0: begin
        path_bytes.push_back(ChAt);
        add_word(1);
      end
      1: path_bytes.push_back(ChRparen);
      2: path_bytes.push_back(ChLparen);
      3: begin
        path_bytes.push_back(8'h00);
        add_word(1);
      end
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      path_bytes.push_back(ChGt);
      if ($urandom_range(0, 3) == 0) add_word($urandom_range(1, 3));
    end
  endfunction

  // ----------------------------------------------------------------- tests
  task automatic test_plain_paths();
    rx_mode = RX_OPEN;
    tx_gaps = 1'b0;
    send_path("<j@e>");
    send_path("\t x@y");
    send_path("a>z");
  endtask

  task automatic test_source_route();
    rx_mode = RX_PATTERN;
    send_path("@r:u");
    send_path("\"@:v");
  endtask

  task automatic test_quoting();
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
    send_path("\"<@\"@d");
    send_path("\\@x@");
    send_path("a\\");
    send_path("c\\", 1'b0);
    send_beat(8'h00, 1'b1);
    send_path("\\", 1'b0);
    send_beat(8'h07, 1'b0);
    send_path("b");
  endtask

  task automatic test_comments();
    send_path("(c)u");
    send_path("u(");
    send_path("(", 1'b0);
    send_beat(8'h00, 1'b0);
    send_path("x");
    send_path("\"()\"");
  endtask

  task automatic test_errors();
    rx_mode = RX_PATTERN;
    send_path("a@@");
    send_path(")");
  endtask

  task automatic test_odd_bytes();
    rx_mode = RX_OPEN;
    tx_gaps = 1'b0;
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h7E, 1'b1);
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_length_cap();
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
    path_bytes.delete();
    repeat (120) path_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
    path_bytes.push_back(ChAt);
    repeat (132) path_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
    path_bytes.push_back(ChBslash);
    path_bytes.push_back(ChAt);
    path_bytes.push_back(8'h7A);
    add_word(4);
    send_queued();
  endtask

  task automatic test_random_paths();
    int first;
    int seg;
    first = beats_sent;
    while (beats_sent - first < RandBeats) begin
      seg     = (beats_sent - first) / 90;
      rx_mode = rx_mode_e'(seg % 3);
      tx_gaps = (seg % 4) != 1;
      build_random_path();
      send_queued();
    end
  endtask

  initial begin
    clear_parse();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_paths();
    test_source_route();
    test_quoting();
    test_comments();
    test_errors();
    test_odd_bytes();
    test_length_cap();
    test_random_paths();
    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && parsed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
